[hw/rtl/wildcard_glob_matcher_defines.svh]
// assertion macros for the glob matcher checker
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// same-cycle implication, held off during reset
`define WGM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define WGM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wgm_pkg.sv]
package wgm_pkg;

    localparam int SYM_W   = 8;
    localparam int POS_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int PADDR_W = 3;

    localparam logic [SYM_W-1:0] SYM_STAR = 8'd42;
    localparam logic [SYM_W-1:0] SYM_ANY  = 8'd63;

    // register index, taken from the word address bit
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_BYTE  = 2'd1,
        FUNC_EMPTY = 2'd2
    } t_func;

endpackage

[hw/rtl/wgm_closure.sv]
module wgm_closure #(
    parameter int N = 128
) (
    input  logic [N:0]   i_seed,
    input  logic [N-1:0] i_prop,
    output logic [N:0]   o_closed
);

    localparam int L = $clog2(N + 1);

    logic [N:0] g [0:L];
    logic [N:0] p [0:L];

    // parallel prefix: position j+1 is reached from j through a star at j
    always_comb begin
        g[0] = i_seed;
        p[0] = {i_prop, 1'b0};
        for (int lv = 0; lv < L; lv++) begin
            for (int j = 0; j <= N; j++) begin
                if (j >= (1 << lv)) begin
                    g[lv+1][j] = g[lv][j] | (p[lv][j] & g[lv][j - (1 << lv)]);
                    p[lv+1][j] = p[lv][j] & p[lv][j - (1 << lv)];
                end else begin
                    g[lv+1][j] = g[lv][j];
                    p[lv+1][j] = 1'b0;
                end
            end
        end
        o_closed = g[L];
    end

endmodule

[hw/rtl/wgm_pattern.sv]
module wgm_pattern import wgm_pkg::*; #(
    parameter int N = 128
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [POS_W-1:0] i_wr_pos,
    input  logic [SYM_W-1:0] i_sym,
    output logic [N-1:0]     o_star,
    output logic [N-1:0]     o_any,
    output logic [N-1:0]     o_eq,
    output logic [N-1:0]     o_star_next
);

    logic [SYM_W-1:0] r_pat [0:N-1];
    logic [N-1:0]     hit;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            hit[i]         = i_wr_en && (int'(i_wr_pos) == i);
            o_star[i]      = (r_pat[i] == SYM_STAR);
            o_any[i]       = (r_pat[i] == SYM_ANY);
            o_eq[i]        = (r_pat[i] == i_sym);
            o_star_next[i] = hit[i] ? (i_sym == SYM_STAR) : o_star[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (hit[i]) begin
                r_pat[i] <= i_sym;
            end
        end
    end

endmodule

[hw/rtl/wildcard_glob_matcher.sv]
// Glob matcher: load the pattern one symbol per item (tuser 0), set its length over
// the register port, then stream string bytes (tuser 1, tlast on the final byte) or
// send an empty string (tuser 2). One result item per string carries the match bit.
// Every pattern position is checked in parallel against each byte and star runs are
// followed by a parallel prefix network, so one item is accepted every cycle while the
// result side keeps up; a result left waiting holds the input. A string's last byte
// passes the input register, and its result is offered from the result register; the
// prefix network over PATTERN_MAX+1 positions between the two registers sets the clock.
// A pattern load or length write restarts any string in progress.
module wildcard_glob_matcher import wgm_pkg::*; #(
    parameter int PATTERN_MAX = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // position[6:0], symbol[14:7], zero
    input  logic [FUNC_W-1:0]  s_axis_tuser,   // func[1:0]
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // matched[0], zero
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int N  = PATTERN_MAX;
    localparam int LW = $clog2(N + 1);

    logic             r_iv;
    t_func            r_func;
    logic [POS_W-1:0] r_pos;
    logic [SYM_W-1:0] r_sym;
    logic             r_last;
    logic [LW-1:0]    r_len;
    logic             r_fresh;
    logic [N:0]       r_act;
    logic [N:0]       r_start;
    logic             r_ov;
    logic             r_matched;

    logic [LW-1:0]    n_len;
    logic             n_fresh;
    logic             n_ov;
    logic             n_matched;

    logic             proc_go;
    logic             cfg_wr;
    logic             wr_en;
    logic             out_we;
    logic             act_we;
    logic [N-1:0]     star;
    logic [N-1:0]     any_sym;
    logic [N-1:0]     eq;
    logic [N-1:0]     star_next;
    logic [N-1:0]     en;
    logic [N-1:0]     en_next;
    logic [N:0]       act;
    logic [N:0]       adv_seed;
    logic [N:0]       adv_closed;
    logic [N:0]       start_next;

    assign proc_go       = r_iv && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_iv || proc_go;
    assign cfg_wr        = psel && penable && pwrite && (paddr[2] == REG_PATTERN_LENGTH);
    assign wr_en         = proc_go && (r_func == FUNC_LOAD) && (int'(r_pos) < N);
    assign act           = r_fresh ? r_start : r_act;

    assign pready        = 1'b1;
    assign prdata        = 32'(r_len);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {7'b0, r_matched};

    always_comb begin
        if (cfg_wr) begin
            if (int'(pwdata[7:0]) > N) begin
                n_len = LW'(N);
            end else begin
                n_len = LW'(pwdata[7:0]);
            end
        end else begin
            n_len = r_len;
        end
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            en[i]      = (i < int'(r_len));
            en_next[i] = (i < int'(n_len));
        end
    end

    // one step of the active set
    always_comb begin
        adv_seed = '0;
        for (int i = 0; i < N; i++) begin
            if (act[i] && en[i]) begin
                if (star[i]) begin
                    adv_seed[i] = 1'b1;
                end else if (any_sym[i] || eq[i]) begin
                    adv_seed[i+1] = 1'b1;
                end
            end
        end
    end

    wgm_pattern #(.N(N)) u_pattern (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_pos    (r_pos),
        .i_sym       (r_sym),
        .o_star      (star),
        .o_any       (any_sym),
        .o_eq        (eq),
        .o_star_next (star_next)
    );

    wgm_closure #(.N(N)) u_adv_closure (
        .i_seed   (adv_seed),
        .i_prop   (star & en),
        .o_closed (adv_closed)
    );

    wgm_closure #(.N(N)) u_start_closure (
        .i_seed   ((N+1)'(1)),
        .i_prop   (star_next & en_next),
        .o_closed (start_next)
    );

    always_comb begin
        n_fresh   = r_fresh;
        n_matched = r_matched;
        out_we    = 1'b0;
        act_we    = 1'b0;
        if (proc_go) begin
            case (r_func)
                FUNC_LOAD: begin
                    n_fresh = 1'b1;
                end
                FUNC_BYTE: begin
                    if (r_last) begin
                        n_fresh   = 1'b1;
                        out_we    = 1'b1;
                        n_matched = adv_closed[r_len];
                    end else begin
                        n_fresh = 1'b0;
                        act_we  = 1'b1;
                    end
                end
                FUNC_EMPTY: begin
                    n_fresh   = 1'b1;
                    out_we    = 1'b1;
                    n_matched = r_start[r_len];
                end
                default: begin
                end
            endcase
        end
        if (cfg_wr) begin
            n_fresh = 1'b1;
        end
        n_ov = out_we || (r_ov && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_len   <= '0;
            r_fresh <= 1'b1;
            r_start <= (N+1)'(1);
            r_ov    <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_iv <= s_axis_tvalid;
            end
            r_len   <= n_len;
            r_fresh <= n_fresh;
            r_start <= start_next;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= t_func'(s_axis_tuser);
            r_pos  <= s_axis_tdata[6:0];
            r_sym  <= s_axis_tdata[14:7];
            r_last <= s_axis_tlast;
        end
        if (act_we) begin
            r_act <= adv_closed;
        end
        if (out_we) begin
            r_matched <= n_matched;
        end
    end

endmodule

[hw/rtl/wgm_checker.sv]
`include "wildcard_glob_matcher_defines.svh"

module wgm_checker import wgm_pkg::*; #(
    parameter int PATTERN_MAX = 128
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [7:0]         m_axis_tdata,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [31:0]        prdata,
    input logic               pready
);

    logic out_stall;
    logic len_wr;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign len_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH);

    `WGM_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "result item dropped while stalled")
    `WGM_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "result item changed")
    `WGM_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0, "result padding not zero")
    `WGM_ASSERT_NEXT(a_len_sat, len_wr, prdata <= 32'(PATTERN_MAX), "pattern length not saturated")

endmodule

bind wildcard_glob_matcher wgm_checker #(.PATTERN_MAX(PATTERN_MAX)) u_wgm_checker (.*);
